// File: rtl/hasm_pkg.sv
// Package for the hierarchical activity skip map.
// Field widths, command codes and the controller/datapath interface structs.
// No dependencies.
package hasm_pkg;

  // Fixed field widths
  localparam int COORD_W = 8;
  localparam int TICK_W  = 31;
  localparam int SKIP_W  = 8;

  // Input command codes
  localparam logic CMD_MARK  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_en;   // write zero at the sweep address in every bank
    logic mark;     // mark transaction accepted this cycle
    logic query;    // query transaction accepted this cycle: read banks, latch fields
    logic load;     // stamps are on the read ports: register the skip distance
  } hasm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last; // sweep address is at the last entry
  } hasm_sts_t;

endpackage

// File: rtl/hasm_ram.sv
// Generic single-port RAM with registered read data.
// Used for every stamp bank of the skip map. No dependencies.
module hasm_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port on one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/hasm_ctrl.sv
// Controller of the skip map: reset clearing sweep, transaction accept, result strobe.
// Depends on hasm_pkg.
module hasm_ctrl
  import hasm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_command,
  input  hasm_sts_t sts,
  output hasm_cmd_t cmd,
  output logic      busy,
  output logic      out_strobe
);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       strobe_r, strobe_nxt;
  logic       accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Datapath commands
  always_comb begin
    cmd.clr_en = (state_r == ST_CLR);
    cmd.mark   = accept && (in_command == CMD_MARK);
    cmd.query  = accept && (in_command == CMD_QUERY);
    cmd.load   = (state_r == ST_READ);
  end

  // Next state
  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_CLR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.query) state_nxt = ST_READ;
      end
      ST_READ: begin
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign out_strobe = strobe_r;

endmodule

// File: rtl/hasm_dp.sv
// Datapath of the skip map: one stamp bank per level, clearing sweep counter,
// staleness compare and skip distance register. Depends on hasm_pkg, hasm_ram.
module hasm_dp
  import hasm_pkg::*;
#(
  parameter int MAP_SIZE = 256,
  parameter int LEVELS   = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hasm_cmd_t          cmd,
  output hasm_sts_t          sts,
  input  logic [COORD_W-1:0] in_cell_x,
  input  logic [COORD_W-1:0] in_cell_y,
  input  logic [TICK_W-1:0]  in_tick_now,
  output logic [SKIP_W-1:0]  out_skip_distance
);

  // Addressable grid: coordinates are 8 bits wide
  localparam int GRID  = (MAP_SIZE < (1 << COORD_W)) ? MAP_SIZE : (1 << COORD_W);
  localparam int CB    = $clog2(GRID);
  localparam int CLR_W = 2 * CB;
  localparam logic [10:0] MAP_LIM = 11'(MAP_SIZE);

  logic [CLR_W-1:0]   clr_cnt_r;
  logic               cell_on_map;
  logic               cell_on_map_r;
  logic [COORD_W-1:0] x_r;
  logic [TICK_W-1:0]  tick_r;
  logic [LEVELS-1:0]  stale;
  logic [SKIP_W-1:0]  skip_r, skip_nxt;

  assign cell_on_map = ({3'b000, in_cell_x} < MAP_LIM) && ({3'b000, in_cell_y} < MAP_LIM);

  // Clearing sweep over the largest bank; smaller banks use the low bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clr_last = (clr_cnt_r == {CLR_W{1'b1}});

  // Query fields held for the compare
  always_ff @(posedge clk) begin
    if (cmd.query) begin
      x_r           <= in_cell_x;
      tick_r        <= in_tick_now;
      cell_on_map_r <= cell_on_map;
    end
  end

  // One stamp bank per level, addressed by the block row and column
  for (genvar n = 0; n < LEVELS; n++) begin : g_lvl
    localparam int LB = (CB > n) ? (CB - n) : 1;
    localparam int AW = 2 * LB;

    logic [COORD_W-1:0] xs, ys;
    logic [AW-1:0]      addr;
    logic [TICK_W-1:0]  wdata, rdata, stamp;
    logic               we;

    assign xs    = in_cell_x >> n;
    assign ys    = in_cell_y >> n;
    assign addr  = cmd.clr_en ? clr_cnt_r[AW-1:0] : {ys[LB-1:0], xs[LB-1:0]};
    assign wdata = cmd.clr_en ? '0 : in_tick_now;
    assign we    = cmd.clr_en || (cmd.mark && cell_on_map);

    hasm_ram #(
      .WIDTH (TICK_W),
      .DEPTH (1 << AW)
    ) u_bank (
      .clk   (clk),
      .we    (we),
      .re    (cmd.query),
      .addr  (addr),
      .wdata (wdata),
      .rdata (rdata)
    );

    // Cells outside the map read as zero stamps
    assign stamp    = cell_on_map_r ? rdata : '0;
    assign stale[n] = (stamp < tick_r);
  end

  // Coarsest stale level wins: ascending scan, last hit kept
  always_comb begin
    skip_nxt = '0;
    for (int n = 0; n < LEVELS; n++) begin
      if (stale[n]) begin
        skip_nxt = SKIP_W'((1 << n) - (int'(x_r) & ((1 << n) - 1)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      skip_r <= skip_nxt;
    end
  end

  assign out_skip_distance = skip_r;

endmodule

// File: rtl/hierarchical_activity_skip_map_top.sv
// Top level of the hierarchical activity skip map.
// Joins hasm_ctrl and hasm_dp; depends on hasm_pkg, hasm_ram.

// After reset the block clears its stamp banks, one entry per cycle in all
// banks at once, over 4^ceil(log2(min(MAP_SIZE,256))) entries of the largest
// bank (65536 at the default size); busy stays high meanwhile. A transaction
// is taken when start is high and busy is low. A mark gives no result and
// leaves busy low: the next transaction may start in the following cycle. A
// query holds busy high in the read state while the registered read of the
// level banks completes; the skip distance is then registered and appears
// with out_strobe for exactly one cycle, in which a new transaction may be
// taken. The receiver cannot stall the result.
module hierarchical_activity_skip_map_top
  import hasm_pkg::*;
#(
  parameter int MAP_SIZE = 256,
  parameter int LEVELS   = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [COORD_W-1:0] in_cell_x,
  input  logic [COORD_W-1:0] in_cell_y,
  input  logic [TICK_W-1:0]  in_tick_now,
  output logic               out_strobe,
  output logic [SKIP_W-1:0]  out_skip_distance
);

  hasm_cmd_t cmd;
  hasm_sts_t sts;

  hasm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  hasm_dp #(
    .MAP_SIZE (MAP_SIZE),
    .LEVELS   (LEVELS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_cell_x         (in_cell_x),
    .in_cell_y         (in_cell_y),
    .in_tick_now       (in_tick_now),
    .out_skip_distance (out_skip_distance)
  );

endmodule
